FILE: rtl/core/brbpa_pkg.sv
// shared widths, codes and controller/datapath interface types for the byte ring buffer
// no dependencies; imported by brbpa_ctrl, brbpa_dp and the top level
`default_nettype none

package brbpa_pkg;

	// fixed field widths
	localparam int OPCODE_W = 2;
	localparam int DATA_W   = 8;
	localparam int RLEN_W   = 7;
	localparam int COUNT_W  = 11;
	localparam int STATUS_W = 2;

	// parameter defaults
	localparam int DEPTH_DEFAULT    = 1024;
	localparam int MAX_READ_DEFAULT = 64;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_READ    = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_REL_ERROR = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic do_write;
		logic do_read;
		logic do_release;
		logic do_other;
		logic run_step;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic read_empty;
		logic run_final;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/brbpa_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module brbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/brbpa_ctrl.sv
// controller for the byte ring buffer: opcode decode and read-run sequencing
// depends on brbpa_pkg
`default_nettype none

module brbpa_ctrl
	import brbpa_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [OPCODE_W-1:0] opcode,
	input  wire dp_stat_t            stat,
	output logic                     busy,
	output ctrl_cmd_t                cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign busy   = (state_q == ST_RUN);
	assign accept = start && !busy;

	always_comb begin
		cmd          = '0;
		cmd.run_step = (state_q == ST_RUN);
		if (accept) begin
			case (opcode)
				OP_WRITE:   cmd.do_write   = 1'b1;
				OP_READ:    cmd.do_read    = 1'b1;
				OP_RELEASE: cmd.do_release = 1'b1;
				default:    cmd.do_other   = 1'b1;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.do_read && !stat.read_empty) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				// last read issued this cycle, its beat shows next cycle
				if (stat.run_final) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/brbpa_dp.sv
// datapath for the byte ring buffer: pointers, fill count, byte store and result registers
// depends on brbpa_pkg and brbpa_ram
`default_nettype none

module brbpa_dp
	import brbpa_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEFAULT,
	parameter int MAX_READ = MAX_READ_DEFAULT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ctrl_cmd_t           cmd,
	output dp_stat_t                 stat,
	input  wire logic [DATA_W-1:0]   data_byte,
	input  wire logic [RLEN_W-1:0]   read_length,
	input  wire logic [COUNT_W-1:0]  release_count,
	output logic                     result_valid,
	output logic [DATA_W-1:0]        read_byte,
	output logic                     byte_valid,
	output logic                     run_last,
	output logic [STATUS_W-1:0]      status,
	output logic [COUNT_W-1:0]       used_count,
	output logic [COUNT_W-1:0]       free_count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam int SUM_W = CMP_W + 1;
	localparam int RUN_W = $clog2(MAX_READ + 1);

	logic [PTR_W-1:0]    head_q;
	logic [PTR_W-1:0]    tail_q;
	logic [CNT_W-1:0]    fill_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [RUN_W-1:0]    run_cnt_q;
	logic                strobe_q;
	logic                valid_q;
	logic                last_q;
	logic [STATUS_W-1:0] status_q;

	logic                full;
	logic [CMP_W-1:0]    fill_ext;
	logic [CMP_W-1:0]    rel_ext;
	logic                rel_over;
	logic [SUM_W-1:0]    head_sum;
	logic [SUM_W-1:0]    head_wrap;
	logic [RLEN_W-1:0]   rlen_cap;
	logic [CMP_W-1:0]    run_len;
	logic [PTR_W-1:0]    tail_next;
	logic [PTR_W-1:0]    rd_ptr_next;
	logic [CNT_W-1:0]    free_cnt;
	logic                ram_we;
	logic [DATA_W-1:0]   ram_rdata;

	assign full     = (fill_q == CNT_W'(DEPTH));
	assign fill_ext = CMP_W'(fill_q);
	assign rel_ext  = CMP_W'(release_count);
	assign rel_over = (rel_ext > fill_ext);

	// head < DEPTH and an accepted release <= DEPTH, so one subtract wraps it
	assign head_sum  = SUM_W'(head_q) + SUM_W'(rel_ext);
	assign head_wrap = (head_sum >= SUM_W'(DEPTH)) ? (head_sum - SUM_W'(DEPTH)) : head_sum;

	assign rlen_cap = (read_length > RLEN_W'(MAX_READ)) ? RLEN_W'(MAX_READ) : read_length;
	assign run_len  = (CMP_W'(rlen_cap) > fill_ext) ? fill_ext : CMP_W'(rlen_cap);

	assign tail_next   = (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign rd_ptr_next = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

	assign stat.read_empty = (run_len == '0);
	assign stat.run_final  = (run_cnt_q == RUN_W'(1));

	assign ram_we = cmd.do_write && !full;

	brbpa_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (data_byte),
		.re    (cmd.run_step),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			fill_q   <= '0;
			strobe_q <= 1'b0;
			valid_q  <= 1'b0;
			last_q   <= 1'b0;
			status_q <= STATUS_OK;
		end else begin
			strobe_q <= 1'b0;
			valid_q  <= 1'b0;
			last_q   <= 1'b1;
			status_q <= STATUS_OK;
			if (cmd.do_write) begin
				strobe_q <= 1'b1;
				if (full) begin
					status_q <= STATUS_FULL;
				end else begin
					tail_q <= tail_next;
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.do_release) begin
				strobe_q <= 1'b1;
				if (rel_over) begin
					status_q <= STATUS_REL_ERROR;
				end else begin
					head_q <= PTR_W'(head_wrap);
					fill_q <= fill_q - CNT_W'(rel_ext);
				end
			end
			if (cmd.do_other || (cmd.do_read && stat.read_empty)) begin
				strobe_q <= 1'b1;
			end
			// one read beat per issued store read
			if (cmd.run_step) begin
				strobe_q <= 1'b1;
				valid_q  <= 1'b1;
				last_q   <= stat.run_final;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_read) begin
			rd_ptr_q  <= head_q;
			run_cnt_q <= RUN_W'(run_len);
		end else if (cmd.run_step) begin
			rd_ptr_q  <= rd_ptr_next;
			run_cnt_q <= run_cnt_q - 1'b1;
		end
	end

	assign free_cnt = CNT_W'(DEPTH) - fill_q;

	assign result_valid = strobe_q;
	assign read_byte    = valid_q ? ram_rdata : '0;
	assign byte_valid   = valid_q;
	assign run_last     = last_q;
	assign status       = status_q;
	assign used_count   = COUNT_W'(fill_q);
	assign free_count   = COUNT_W'(free_cnt);

endmodule

`default_nettype wire

FILE: rtl/core/byte_ring_buffer_peek_ack_core.sv
// top level of the circular byte buffer with peek reads and acknowledged release
// depends on brbpa_pkg, brbpa_ctrl, brbpa_dp (which holds brbpa_ram)
//
// Usage: a command beat is taken on a rising edge with start high and busy low.
// opcode 0 appends data_byte at the tail, 1 peeks up to read_length bytes from the
// head without consuming them, 2 drops release_count bytes from the head.
// Every result beat is shown for one cycle with result_valid high; the receiver
// cannot stall, so each beat must be taken when it appears. used_count and
// free_count give the fill after the command.
// Latency: the result of a write, release, empty read or unused opcode appears
// the cycle after acceptance; busy stays low and such commands go one per cycle.
// A read of n bytes (n = min(read_length, MAX_READ, used)) holds busy high while its
// store reads issue and gives one byte per cycle from the single read port of the
// byte store via its registered read data; a new command is taken when busy drops.
// Reset clears the head and tail pointers and the fill count; store contents are not cleared
// and need no clearing pass since only written bytes can be read.
`default_nettype none

module byte_ring_buffer_peek_ack_core
	import brbpa_pkg::*;
#(
	parameter int DEPTH    = DEPTH_DEFAULT,
	parameter int MAX_READ = MAX_READ_DEFAULT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic [OPCODE_W-1:0] opcode,
	input  wire logic [DATA_W-1:0]   data_byte,
	input  wire logic [RLEN_W-1:0]   read_length,
	input  wire logic [COUNT_W-1:0]  release_count,
	output logic                     result_valid,
	output logic [DATA_W-1:0]        read_byte,
	output logic                     byte_valid,
	output logic                     run_last,
	output logic [STATUS_W-1:0]      status,
	output logic [COUNT_W-1:0]       used_count,
	output logic [COUNT_W-1:0]       free_count
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	brbpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	brbpa_dp #(
		.DEPTH    (DEPTH),
		.MAX_READ (MAX_READ)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.data_byte     (data_byte),
		.read_length   (read_length),
		.release_count (release_count),
		.result_valid  (result_valid),
		.read_byte     (read_byte),
		.byte_valid    (byte_valid),
		.run_last      (run_last),
		.status        (status),
		.used_count    (used_count),
		.free_count    (free_count)
	);

endmodule

`default_nettype wire
